[rtl/lcdseq_pkg.sv]
// Shared types, constants and helpers for the character LCD nibble write sequencer.
// No dependencies; every module of the block imports this package.

package lcdseq_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 20;
   localparam int PULSE_WIDTH         = 8;
   localparam int SHORT_WIDTH         = 16;
   localparam int LEN_WIDTH           = 20;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int INIT_LEN            = 5;

   localparam logic [PULSE_WIDTH-1:0] PULSE_RESET = 8'd1;
   localparam logic [SHORT_WIDTH-1:0] SHORT_RESET = 16'd100;
   localparam logic [LEN_WIDTH-1:0]   LONG_RESET  = 20'd2000;
   localparam logic [LEN_WIDTH-1:0]   POWER_RESET = 20'd20000;

   localparam logic [7:0] INSTR_CLEAR = 8'h01;
   localparam logic [7:0] INSTR_HOME  = 8'h02;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_INSTR = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PULSE = 2'd0,
      CSR_SHORT = 2'd1,
      CSR_LONG  = 2'd2,
      CSR_POWER = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] byte_value;
   } req_payload_type;

   typedef struct packed {
      logic       en_pin;
      logic       rs_pin;
      logic       rw_pin;
      logic [3:0] nibble_pins;
      logic       busy_res;
      logic       accepted;
   } rsp_payload_type;

   typedef struct packed {
      logic [PULSE_WIDTH-1:0] pulse_ticks;
      logic [SHORT_WIDTH-1:0] short_wait_ticks;
      logic [LEN_WIDTH-1:0]   long_wait_ticks;
      logic [LEN_WIDTH-1:0]   power_on_ticks;
   } cfg_type;

   // Power-up instruction bytes: 8-bit wake twice, 4-bit mode, 2 lines,
   // display on with cursor, clear.
   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      b = 8'h00;
      case (step)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h28;
         3'd3:    b = 8'h0e;
         3'd4:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[rtl/lcdseq_csr.sv]
// Configuration register file: pulse, settle and power-on durations.
// Depends on lcdseq_pkg.

module lcdseq_csr
   import lcdseq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PULSE: cfg_in.pulse_ticks      = csr_data[PULSE_WIDTH-1:0];
            CSR_SHORT: cfg_in.short_wait_ticks = csr_data[SHORT_WIDTH-1:0];
            CSR_LONG:  cfg_in.long_wait_ticks  = csr_data[LEN_WIDTH-1:0];
            CSR_POWER: cfg_in.power_on_ticks   = csr_data[LEN_WIDTH-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks      <= PULSE_RESET;
         cfg_ff.short_wait_ticks <= SHORT_RESET;
         cfg_ff.long_wait_ticks  <= LONG_RESET;
         cfg_ff.power_on_ticks   <= POWER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/lcdseq_core.sv]
// Sequencer state and per-tick pin computation; one tick per accepted transaction.
// Depends on lcdseq_pkg.

module lcdseq_core
   import lcdseq_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            tick,
   input  req_payload_type req,
   input  cfg_type         cfg,
   output rsp_payload_type rsp
);

   localparam int CMP_W = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;

   typedef enum logic [2:0] {
      PH_POWER  = 3'd0,
      PH_HI_EN  = 3'd1,
      PH_HI_GAP = 3'd2,
      PH_LO_EN  = 3'd3,
      PH_LO_GAP = 3'd4,
      PH_SETTLE = 3'd5,
      PH_IDLE   = 3'd6
   } phase_type;

   phase_type              phase_ff, phase_in, phase_cur;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in, count_cur, count_inc;
   logic [7:0]             held_byte_ff, held_byte_in, byte_cur;
   logic                   held_select_ff, held_select_in, select_cur;
   logic [2:0]             init_step_ff, init_step_in;
   logic                   take;
   logic [LEN_WIDTH-1:0]   length;
   logic                   done;
   logic                   load_init;

   always_comb begin
      take = (phase_ff == PH_IDLE) &&
             ((cmd_type'(req.cmd) == CMD_INSTR) || (cmd_type'(req.cmd) == CMD_DATA));

      phase_cur  = take ? PH_HI_EN : phase_ff;
      byte_cur   = take ? req.byte_value : held_byte_ff;
      select_cur = take ? (cmd_type'(req.cmd) == CMD_DATA) : held_select_ff;
      count_cur  = take ? '0 : tick_count_ff;

      rsp.en_pin      = (phase_cur == PH_HI_EN) || (phase_cur == PH_LO_EN);
      rsp.rs_pin      = select_cur;
      rsp.rw_pin      = 1'b0;
      rsp.nibble_pins = ((phase_cur == PH_HI_EN) || (phase_cur == PH_HI_GAP)) ?
                        byte_cur[7:4] : byte_cur[3:0];
      rsp.busy_res    = (phase_cur != PH_IDLE);
      rsp.accepted    = take;

      unique case (phase_cur)
         PH_POWER: length = cfg.power_on_ticks;
         PH_HI_EN, PH_HI_GAP, PH_LO_EN, PH_LO_GAP:
            length = LEN_WIDTH'(cfg.pulse_ticks);
         PH_SETTLE: begin
            if (!select_cur && ((byte_cur == INSTR_CLEAR) || (byte_cur == INSTR_HOME)))
               length = cfg.long_wait_ticks;
            else
               length = LEN_WIDTH'(cfg.short_wait_ticks);
         end
         default: length = LEN_WIDTH'(1);
      endcase

      // Saturate the counter; a zero length behaves as one since count_inc >= 1.
      count_inc = (&count_cur) ? count_cur : count_cur + COUNT_WIDTH'(1);
      done      = (CMP_W'(count_inc) >= CMP_W'(length)) || (&count_inc);

      phase_in       = phase_cur;
      held_byte_in   = byte_cur;
      held_select_in = select_cur;
      init_step_in   = init_step_ff;
      tick_count_in  = count_inc;
      load_init      = 1'b0;

      if (phase_cur == PH_IDLE) begin
         tick_count_in = '0;
      end else if (done) begin
         tick_count_in = '0;
         unique case (phase_cur)
            PH_POWER:  load_init = 1'b1;
            PH_HI_EN:  phase_in  = PH_HI_GAP;
            PH_HI_GAP: phase_in  = PH_LO_EN;
            PH_LO_EN:  phase_in  = PH_LO_GAP;
            PH_LO_GAP: phase_in  = PH_SETTLE;
            PH_SETTLE: begin
               if (init_step_ff < 3'(INIT_LEN)) load_init = 1'b1;
               else                             phase_in  = PH_IDLE;
            end
            default:   phase_in  = PH_IDLE;
         endcase
      end

      if (load_init) begin
         held_byte_in   = init_byte(init_step_ff);
         held_select_in = 1'b0;
         init_step_in   = init_step_ff + 3'd1;
         phase_in       = PH_HI_EN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_POWER;
         tick_count_ff  <= '0;
         held_byte_ff   <= '0;
         held_select_ff <= 1'b0;
         init_step_ff   <= '0;
      end else if (tick) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         held_byte_ff   <= held_byte_in;
         held_select_ff <= held_select_in;
         init_step_ff   <= init_step_in;
      end
   end

endmodule

[rtl/lcdseq_out_buf.sv]
// Result register with skid stage; parts the request side from a stalled receiver.
// Depends on lcdseq_pkg.

module lcdseq_out_buf
   import lcdseq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            can_push,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            main_valid_ff, skid_valid_ff;
   rsp_payload_type main_data_ff, skid_data_ff;
   logic            pop;

   assign can_push  = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;
   assign pop       = main_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) main_valid_ff <= 1'b1;
         else                       skid_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) main_data_ff <= skid_data_ff;
      end else if (push) begin
         if (!main_valid_ff || pop) main_data_ff <= push_data;
         else                       skid_data_ff <= push_data;
      end
   end

endmodule

[rtl/char_lcd_nibble_write_sequencer.sv]
// Top level of the character LCD 4-bit write sequencer.
// Depends on lcdseq_pkg, lcdseq_csr, lcdseq_core and lcdseq_out_buf.
//
// Usage:
//   req_*  : one transaction per time tick. cmd selects tick only, instruction
//            write or data write; byte_value is the byte to send.
//   rsp_*  : one transaction per request: EN, RS, RW, D7..D4 levels for that
//            tick, plus busy and whether the tick's write request was taken.
//   csr_*  : duration registers (pulse, short settle, long settle, power-on),
//            always ready; write them only while no tick is in flight.
// Output: the response for a tick is registered in the output buffer when the
//   request is taken. Throughput: one tick per cycle while req_ready is high,
//   set by the registered state update of the sequencer core.
// Reset: durations return to their defaults, the sequencer enters the
//   power-on wait and then sends the five init instructions by itself.
// Receiver stall: a two-entry output (result register plus skid) lets one more
//   tick in; req_ready then drops until the receiver drains it.

module char_lcd_nibble_write_sequencer
   import lcdseq_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type         cfg;
   rsp_payload_type core_rsp;
   logic            tick;

   assign tick = req_valid && req_ready;

   lcdseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lcdseq_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .tick  (tick),
      .req   (req_data),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   lcdseq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (tick),
      .push_data (core_rsp),
      .can_push  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/lcdseq_checker.sv]
// Port-level checks for the LCD write sequencer, attached by bind.
// Depends on lcdseq_pkg and char_lcd_nibble_write_sequencer.

module lcdseq_checker
   import lcdseq_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_rw_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.rw_pin)
      else $error("rw pin driven high");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.busy_res && rsp_data.en_pin)
      else $error("taken request did not start an enable pulse");

   a_en_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.en_pin |-> rsp_data.busy_res)
      else $error("enable pulse while idle");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready)
      else $error("request side not ready after reset");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
